// File: rtl/ist_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ist_pkg;

  localparam int CAPACITY = 16;
  localparam int ID_BITS  = 32;
  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_DEL   = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_LIST  = 2'd3
  } ist_action_t;

  typedef struct packed {
    ist_action_t        action;
    logic [ID_BITS-1:0] item_id;
  } ist_in_t;

  typedef struct packed {
    logic                status;
    logic                found;
    logic [CNT_BITS-1:0] element_count;
    logic [ID_BITS-1:0]  element_id;
    logic                last;
  } ist_out_t;

  // per-cell move command
  typedef struct packed {
    logic shift_r;  // take the left neighbor (insert at front)
    logic shift_l;  // take the right neighbor (close a gap)
  } ist_ctl_t;

endpackage
`default_nettype wire

// File: rtl/id_set_table.sv
`timescale 1ns / 1ps
// add/delete/query: one transaction per cycle unless stalled, result registered
// in the cycle after acceptance; all slot cells compare the id in parallel
// list: held-count results, one per free cycle, input held off to the final one
// throughput is set by the single output register and the list read-out counter
// reset (synchronous, rst_n low) empties the set; slot ids are not cleared
`default_nettype none
module id_set_table (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  ist_pkg::ist_in_t  in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output ist_pkg::ist_out_t out_data
);
  import ist_pkg::*;

  logic [ID_BITS-1:0]  cell_id [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] ge;
  ist_ctl_t            ctl [CAPACITY];

  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic [IDX_BITS-1:0] idx_r, idx_nxt;
  logic                busy_r, busy_nxt;
  logic                out_valid_r, out_valid_nxt;
  ist_out_t            out_r, out_nxt;

  logic take, out_free, hit, full, load;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [ID_BITS-1:0] l_id, r_id;
      logic               l_valid, r_valid;
      if (g == 0) begin : g_head
        assign l_id    = in_data.item_id;
        assign l_valid = 1'b1;
      end else begin : g_mid
        assign l_id    = cell_id[g-1];
        assign l_valid = cell_valid[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign r_id    = cell_id[g];
        assign r_valid = 1'b0;
      end else begin : g_body
        assign r_id    = cell_id[g+1];
        assign r_valid = cell_valid[g+1];
      end
      ist_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl[g]),
        .key         (in_data.item_id),
        .left_id     (l_id),
        .left_valid  (l_valid),
        .right_id    (r_id),
        .right_valid (r_valid),
        .id          (cell_id[g]),
        .valid       (cell_valid[g]),
        .match       (match[g])
      );
    end
  endgenerate

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = busy_r || !out_free;
  assign take     = in_valid && !in_stall;
  assign hit      = |match;
  assign full     = (count_r == CNT_BITS'(CAPACITY));

  // cells at and after the matching slot pull from their right neighbor
  always_comb begin
    ge[0] = match[0];
    for (int i = 1; i < CAPACITY; i++) begin
      ge[i] = ge[i-1] | match[i];
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i] = '0;
    end
    count_nxt = count_r;
    idx_nxt   = idx_r;
    busy_nxt  = busy_r;
    load      = 1'b0;
    out_nxt   = out_r;
    if (take) begin
      load                  = 1'b1;
      out_nxt.status        = 1'b0;
      out_nxt.found         = 1'b0;
      out_nxt.element_id    = '0;
      out_nxt.last          = 1'b1;
      case (in_data.action)
        ACT_ADD: begin
          if (!hit && !full) begin
            for (int i = 0; i < CAPACITY; i++) begin
              ctl[i].shift_r = 1'b1;
            end
            count_nxt = count_r + CNT_BITS'(1);
          end
          out_nxt.status = !hit && full;
        end
        ACT_DEL: begin
          if (hit) begin
            for (int i = 0; i < CAPACITY; i++) begin
              ctl[i].shift_l = ge[i];
            end
            count_nxt = count_r - CNT_BITS'(1);
          end
          out_nxt.status = !hit;
        end
        ACT_QUERY: begin
          out_nxt.found = hit;
        end
        ACT_LIST: begin
          if (count_r == '0) begin
            out_nxt.status = 1'b1;
          end else begin
            out_nxt.element_id = cell_id[0];
            out_nxt.last       = (count_r == CNT_BITS'(1));
            busy_nxt           = (count_r != CNT_BITS'(1));
            idx_nxt            = IDX_BITS'(1);
          end
        end
        default: begin
          out_nxt.status = 1'b1;
        end
      endcase
      out_nxt.element_count = count_nxt;
    end else if (busy_r && out_free) begin
      load                  = 1'b1;
      out_nxt.status        = 1'b0;
      out_nxt.found         = 1'b0;
      out_nxt.element_count = count_r;
      out_nxt.element_id    = cell_id[idx_r];
      out_nxt.last          = ((CNT_BITS'(idx_r) + CNT_BITS'(1)) == count_r);
      busy_nxt              = !out_nxt.last;
      idx_nxt               = idx_r + IDX_BITS'(1);
    end
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    idx_r <= idx_nxt;
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: rtl/ist_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module ist_cell (
  input  wire                         clk,
  input  wire                         rst_n,
  input  ist_pkg::ist_ctl_t           ctl,
  input  wire [ist_pkg::ID_BITS-1:0]  key,
  input  wire [ist_pkg::ID_BITS-1:0]  left_id,
  input  wire                         left_valid,
  input  wire [ist_pkg::ID_BITS-1:0]  right_id,
  input  wire                         right_valid,
  output logic [ist_pkg::ID_BITS-1:0] id,
  output logic                        valid,
  output logic                        match
);
  import ist_pkg::*;

  logic [ID_BITS-1:0] id_r, id_nxt;
  logic               valid_r, valid_nxt;

  always_comb begin
    id_nxt    = id_r;
    valid_nxt = valid_r;
    if (ctl.shift_r) begin
      id_nxt    = left_id;
      valid_nxt = left_valid;
    end else if (ctl.shift_l) begin
      id_nxt    = right_id;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign id    = id_r;
  assign valid = valid_r;
  assign match = valid_r && (id_r == key);

endmodule
`default_nettype wire

// File: rtl/ist_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module ist_chk (
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_stall,
  input ist_pkg::ist_in_t  in_data,
  input wire               out_valid,
  input wire               out_stall,
  input ist_pkg::ist_out_t out_data
);
  import ist_pkg::*;

  // every accepted transaction shows a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("no result after accepted input");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.element_count <= CNT_BITS'(CAPACITY))
    else $error("count beyond capacity");

  // a query hit is a single ok result
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> !out_data.status && out_data.last)
    else $error("found with error or not last");

endmodule

bind id_set_table ist_chk u_ist_chk (.*);
`default_nettype wire

// File: verif/id_set_checker.sv
`timescale 1ns / 1ps
module id_set_checker (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_stall,
  input  ist_pkg::ist_in_t  in_data,
  input  wire               out_valid,
  input  wire               out_stall,
  input  ist_pkg::ist_out_t out_data,
  output int                fail_count,
  output int                pending
);
  import ist_pkg::*;

  // shadow of the table, slot 0 holds the newest id
  logic [ID_BITS-1:0] held_ids [CAPACITY];
  int                 held_n;
  ist_out_t           expected_q [$];

  function automatic int locate(logic [ID_BITS-1:0] id);
    for (int i = 0; i < held_n; i++) begin
      if (held_ids[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void push_result(logic st, logic fnd, logic [ID_BITS-1:0] eid,
                                      logic lst);
    ist_out_t r;
    r.status        = st;
    r.found         = fnd;
    r.element_count = held_n[CNT_BITS-1:0];
    r.element_id    = eid;
    r.last          = lst;
    expected_q.push_back(r);
  endfunction

  task automatic apply_txn(ist_in_t t);
    int pos;
    pos = locate(t.item_id);
    case (t.action)
      ACT_ADD: begin
        if (pos >= 0) begin
          push_result(1'b0, 1'b0, '0, 1'b1);
        end else if (held_n >= CAPACITY) begin
          push_result(1'b1, 1'b0, '0, 1'b1);
        end else begin
          for (int i = held_n; i > 0; i--) held_ids[i] = held_ids[i-1];
          held_ids[0] = t.item_id;
          held_n++;
          push_result(1'b0, 1'b0, '0, 1'b1);
        end
      end
      ACT_DEL: begin
        // an empty set also lands here since nothing is found
        if (pos < 0) begin
          push_result(1'b1, 1'b0, '0, 1'b1);
        end else begin
          for (int i = pos; i + 1 < held_n; i++) held_ids[i] = held_ids[i+1];
          held_n--;
          push_result(1'b0, 1'b0, '0, 1'b1);
        end
      end
      ACT_QUERY: begin
        push_result(1'b0, pos >= 0, '0, 1'b1);
      end
      default: begin
        if (held_n == 0) begin
          push_result(1'b1, 1'b0, '0, 1'b1);
        end else begin
          for (int i = 0; i < held_n; i++) begin
            push_result(1'b0, 1'b0, held_ids[i], i == held_n - 1);
          end
        end
      end
    endcase
  endtask

  task automatic check_result(ist_out_t got);
    ist_out_t exp;
    logic     bad;
    if (expected_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("id_set_checker: unexpected transaction st=%0d fnd=%0d cnt=%0d id=%h last=%0d",
                 got.status, got.found, got.element_count, got.element_id, got.last);
    end else begin
      exp = expected_q.pop_front();
      bad = (got.status !== exp.status) || (got.found !== exp.found) ||
            (got.element_count !== exp.element_count) ||
            (got.element_id !== exp.element_id) || (got.last !== exp.last);
      if (bad) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("id_set_checker: mismatch exp st=%0d fnd=%0d cnt=%0d id=%h last=%0d",
                   exp.status, exp.found, exp.element_count, exp.element_id, exp.last);
          $display("id_set_checker:          got st=%0d fnd=%0d cnt=%0d id=%h last=%0d",
                   got.status, got.found, got.element_count, got.element_id, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_n = 0;
      expected_q.delete();
      pending = 0;
    end else begin
      // a result always trails the transaction that caused it, so order here is free
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) apply_txn(in_data);
      pending = expected_q.size();
    end
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import ist_pkg::*;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ist_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ist_out_t out_data;
  int       fail_count;
  int       pending;
  int       send_idle_pct;
  int       recv_idle_pct;
  logic [ID_BITS-1:0] id_pool [20];

  id_set_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  id_set_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("tb_top: FAIL");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic send_txn(ist_action_t act, logic [ID_BITS-1:0] id);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_data.action  <= act;
    in_data.item_id <= id;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int          r;
    bit          fill_mode;
    ist_action_t act;
    logic [ID_BITS-1:0] id;

    send_idle_pct = 15;
    recv_idle_pct = 77;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < 20; i++) id_pool[i] = $urandom;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty set corner cases, duplicates and absent ids
    send_txn(ACT_LIST, $urandom);
    send_txn(ACT_DEL, 32'h0000_0005);
    send_txn(ACT_ADD, 32'h0000_0000);
    send_txn(ACT_ADD, 32'hFFFF_FFFF);
    send_txn(ACT_ADD, 32'h0000_0000);
    send_txn(ACT_QUERY, 32'h0000_0000);
    send_txn(ACT_QUERY, 32'h0000_0005);
    send_txn(ACT_DEL, 32'h1234_5678);
    drain();
    // fill to capacity, then overflow
    for (int i = 0; i < CAPACITY - 2; i++) send_txn(ACT_ADD, 32'h1 << i);
    send_txn(ACT_ADD, 32'h7777_7777);
    send_txn(ACT_LIST, $urandom);
    // remove from the middle, the front and the back
    send_txn(ACT_DEL, 32'h1 << 6);
    send_txn(ACT_DEL, 32'h1 << (CAPACITY - 3));
    send_txn(ACT_DEL, 32'h0000_0000);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      fill_mode = 1'b1;
      for (int n = 0; n < 44; n++) begin
        // swing between growing toward full and shrinking toward empty
        if (n % 18 == 0) fill_mode = (n % 36 == 0);
        r = $urandom_range(0, 99);
        if (fill_mode)
          act = (r < 55) ? ACT_ADD : (r < 70) ? ACT_DEL : (r < 90) ? ACT_QUERY : ACT_LIST;
        else
          act = (r < 20) ? ACT_ADD : (r < 65) ? ACT_DEL : (r < 85) ? ACT_QUERY : ACT_LIST;
        id = ($urandom_range(0, 9) == 0) ? ID_BITS'($urandom) :
             id_pool[$urandom_range(0, 19)];
        send_txn(act, id);
      end
      drain();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
